[design/xtsc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the XOR-target subarray counter.
// No dependencies; imported by xtsc_occ_table and xor_target_subarray_counter.
package xtsc_pkg;

  // Fixed field widths of the channels
  localparam int VALUE_W  = 10;
  localparam int TARGET_W = 10;
  localparam int COUNT_W  = 24;
  localparam int OCC_W    = 13;

  // Defaults for the top-level parameters
  localparam int VALUE_BITS_DEF = 10;
  localparam int MAX_LEN_DEF    = 4096;

  typedef logic [OCC_W-1:0] occ_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } in_beat_t;

  typedef struct packed {
    logic [COUNT_W-1:0] subarray_count;
    logic               overflow;
  } out_beat_t;

endpackage

[design/xtsc_occ_table.sv]
`timescale 1ns / 1ps
// Prefix occurrence table: one write port, two registered read ports.
// Depends on xtsc_pkg for the entry type.
module xtsc_occ_table #(
  parameter int ADDR_W = xtsc_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output xtsc_pkg::occ_t    rd_data_a,
  output xtsc_pkg::occ_t    rd_data_b,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  xtsc_pkg::occ_t    wr_data
);
  import xtsc_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  occ_t mem [DEPTH];
  occ_t rd_a_r;
  occ_t rd_b_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read ports, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

[design/xor_target_subarray_counter.sv]
`timescale 1ns / 1ps
// Result path: the beat marked last is registered into stage 1, then into the output register that drives out_valid.
// Throughput: one beat per cycle within an array, but a last beat waits while out_valid is high;
// the table read-modify-write is two stages with forwarding from the pending write, so back-to-back
// beats to the same entry need no stall. After reset and after every last beat a clearing pass writes
// all 2**VALUE_BITS table entries, one per cycle, with in_ready low; configuration is taken throughout.
// Reset is synchronous, active low; target_r resets to zero.
module xor_target_subarray_counter #(
  parameter int VALUE_BITS = xtsc_pkg::VALUE_BITS_DEF,
  parameter int MAX_LEN    = xtsc_pkg::MAX_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  xtsc_pkg::in_beat_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output xtsc_pkg::out_beat_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [xtsc_pkg::TARGET_W-1:0]     cfg_data
);
  import xtsc_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  typedef logic [VALUE_BITS-1:0] key_t;

  // Configuration and array state
  logic [TARGET_W-1:0] target_r;
  key_t                prefix_r;
  logic [CNT_W-1:0]    elem_cnt_r;
  logic                ovf_r;
  logic [COUNT_W-1:0]  total_r;

  // Clearing sweep
  logic clr_active_r;
  key_t clr_idx_r;

  // Second stage of the read-modify-write
  logic s1_vld_r;
  logic s1_upd_r;
  logic s1_last_r;
  logic s1_ovf_r;
  key_t s1_key_r;
  logic fwd_p_r;
  logic fwd_w_r;
  occ_t fwd_data_r;

  // Output register
  logic      out_valid_r;
  out_beat_t out_data_r;

  // Stage 0 signals
  logic in_fire;
  logic room;
  key_t v_key;
  key_t tgt_key;
  key_t p_new;
  key_t want;
  logic hit_p;
  logic hit_w;

  // Stage 1 signals
  occ_t               rd_p;
  occ_t               rd_w;
  occ_t               occ_p;
  occ_t               occ_w;
  occ_t               occ_inc;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] total_sat;
  logic [COUNT_W-1:0] total_upd;
  logic               s1_write;

  // Table write port
  logic tbl_wr_en;
  key_t tbl_wr_addr;
  occ_t tbl_wr_data;

  // Hold all beats during the clearing sweep, and a last beat while a result still waits in the output register
  assign in_ready  = !clr_active_r && !(in_data.last && out_valid_r);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Fold the beat into the prefix and form the lookup key
  assign v_key   = VALUE_BITS'(in_data.value);
  assign tgt_key = VALUE_BITS'(target_r);
  assign room    = elem_cnt_r < CNT_W'(MAX_LEN);
  assign p_new   = prefix_r ^ v_key;
  assign want    = p_new ^ tgt_key;

  // Detect reads that miss the write landing at the same edge
  assign s1_write = s1_vld_r && s1_upd_r && !s1_last_r;
  assign hit_p    = s1_write && (s1_key_r == p_new);
  assign hit_w    = s1_write && (s1_key_r == want);

  // Merge forwarded data, increment with saturation, accumulate
  assign occ_p     = fwd_p_r ? fwd_data_r : rd_p;
  assign occ_w     = fwd_w_r ? fwd_data_r : rd_w;
  assign occ_inc   = (occ_p == '1) ? occ_p : occ_p + 1'b1;
  assign sum       = {1'b0, total_r} + (COUNT_W + 1)'(occ_w);
  assign total_sat = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
  assign total_upd = s1_upd_r ? total_sat : total_r;

  // Table write: clearing sweep or the pipeline update
  always_comb begin
    if (clr_active_r) begin
      tbl_wr_en   = 1'b1;
      tbl_wr_addr = clr_idx_r;
      tbl_wr_data = (clr_idx_r == '0) ? occ_t'(1) : '0;
    end else begin
      tbl_wr_en   = s1_write;
      tbl_wr_addr = s1_key_r;
      tbl_wr_data = occ_inc;
    end
  end

  xtsc_occ_table #(
    .ADDR_W (VALUE_BITS)
  ) u_table (
    .clk       (clk),
    .rd_en     (in_fire && room),
    .rd_addr_a (p_new),
    .rd_addr_b (want),
    .rd_data_a (rd_p),
    .rd_data_b (rd_w),
    .wr_en     (tbl_wr_en),
    .wr_addr   (tbl_wr_addr),
    .wr_data   (tbl_wr_data)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_valid) begin
      target_r <= cfg_data;
    end
  end

  // Stage 0 state: prefix, element count, overflow, clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r     <= '0;
      elem_cnt_r   <= '0;
      ovf_r        <= 1'b0;
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
    end else begin
      if (clr_active_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == '1) begin
          clr_active_r <= 1'b0;
        end
      end
      if (in_fire) begin
        if (in_data.last) begin
          prefix_r     <= '0;
          elem_cnt_r   <= '0;
          ovf_r        <= 1'b0;
          clr_active_r <= 1'b1;
          clr_idx_r    <= '0;
        end else if (room) begin
          prefix_r   <= p_new;
          elem_cnt_r <= elem_cnt_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  // Advance the beat into stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    s1_upd_r   <= room;
    s1_last_r  <= in_data.last;
    s1_ovf_r   <= ovf_r || !room;
    s1_key_r   <= p_new;
    fwd_p_r    <= hit_p;
    fwd_w_r    <= hit_w;
    fwd_data_r <= occ_inc;
  end

  // Running total: accumulate, drop at the end of an array
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (s1_vld_r) begin
      total_r <= s1_last_r ? '0 : total_upd;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_vld_r && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && s1_last_r) begin
      out_data_r.subarray_count <= total_upd;
      out_data_r.overflow       <= s1_ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result never lands on a waiting one
  a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s1_last_r |-> !out_valid_r)
    else $error("result produced while output register is full");

  // The end of an array always starts a clearing sweep
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s1_last_r |-> clr_active_r)
    else $error("last beat did not start the clearing sweep");

  // The sweep and a pipeline update never share the write port
  a_no_wr_collide: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !s1_write)
    else $error("table update during clearing sweep");

  // The element count stops at the array limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    elem_cnt_r <= CNT_W'(MAX_LEN))
    else $error("element count past limit");

endmodule
